// ----- rtl/sptm_pkg.sv -----
// Package: constants, types and opcodes for the sparse polynomial term engine.
`default_nettype none
package sptm_pkg;
   localparam int MAX_TERMS  = 32;
   localparam int EXP_BITS   = 8;
   localparam int IDX_BITS   = $clog2(MAX_TERMS);
   localparam int CNT_BITS   = $clog2(MAX_TERMS + 1);
   localparam int COEFF_BITS = 32;
   localparam int OP_BITS    = 3;
   localparam int EXP_W      = 8;
   localparam int TCNT_W     = 6;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_EVAL   = 3'd1,
      OP_LIST   = 3'd2,
      OP_DERIV  = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef struct packed {
      logic [OP_BITS-1:0]    operation;
      logic [COEFF_BITS-1:0] coeff_in;
      logic [EXP_W-1:0]      exp_in;
      logic [COEFF_BITS-1:0] x_value;
   } req_type;

   typedef struct packed {
      logic [COEFF_BITS-1:0] value;
      logic [COEFF_BITS-1:0] out_coeff;
      logic [EXP_W-1:0]      out_exp;
      logic                  term_valid;
      logic [TCNT_W-1:0]     term_count;
      logic                  status;
      logic                  last;
   } rsp_type;
endpackage
`default_nettype wire

// ----- rtl/sptm_if.sv -----
// Valid/ready channel interfaces, each carrying one word of its fixed payload type.
`default_nettype none
interface sptm_req_if;
   import sptm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sptm_rsp_if;
   import sptm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/sparse_polynomial_term_engine.sv -----
// Sparse polynomial term engine: sorted term table in RAM with a sequencer.
//
// Channels: req (operation, coeff_in, exp_in, x_value) in, rsp out, both
// valid/ready; a word moves when valid and ready are high at a clock edge.
// The term table sits in one synchronous RAM with a registered read port, one
// entry per term, sorted by descending exponent; a counter holds the size.
// One request is worked at a time; req_ready is high only when idle and no
// word is waiting.
// Insert: each entry scanned passes S_RD, S_WAIT and S_SCAN, then each entry
// moved to open or close a gap passes S_SHRD and S_SHWR.
// Evaluate: a term is fetched via S_RD, S_WAIT and S_TERM, then takes S_POW
// and S_MUL per exponent bit (square-and-multiply) and ends in S_POW and
// S_ACC. List and derivative: a term passes S_RD, S_WAIT, S_TERM and
// S_EMIT; a word goes out one term late so the final one can carry last,
// and S_TAIL sends the closing word. Clear and empty-table requests answer
// the cycle after acceptance. An empty-table nonzero insert scans first.
// A stalled receiver holds the sequencer in its emit state; no word is lost.
// Synchronous reset empties the table at once (size counter to zero).
`default_nettype none
module sparse_polynomial_term_engine
   import sptm_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   sptm_req_if.sink   req,
   sptm_rsp_if.source rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_WAIT, S_SCAN, S_SHRD, S_SHWR,
      S_POW, S_MUL, S_ACC, S_TERM, S_EMIT, S_TAIL
   } state_type;

   localparam int ENT_W = COEFF_BITS + EXP_BITS;

   logic [ENT_W-1:0] mem [MAX_TERMS];
   logic [ENT_W-1:0] rd_data_ff;
   logic [IDX_BITS-1:0] rd_addr, wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type state_ff;
   req_type   req_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] idx_ff;
   logic [CNT_BITS-1:0] sh_ff;
   logic                sh_up_ff;
   logic [COEFF_BITS-1:0] acc_ff, pw_ff, base_ff, prod_ff;
   logic [EXP_BITS-1:0]   e_ff;
   logic [COEFF_BITS-1:0] tc_ff;
   logic [EXP_BITS-1:0]   te_ff;
   logic [COEFF_BITS-1:0] hold_c_ff;
   logic [EXP_BITS-1:0]   hold_e_ff;
   logic                  any_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [COEFF_BITS-1:0] rc;
   logic [EXP_BITS-1:0]   re;
   logic [EXP_BITS-1:0]   ein;
   logic [COEFF_BITS-1:0] sum;
   logic                  skip;
   logic                  fin;
   logic                  emit_out;
   logic                  rsp_load;
   assign rc  = rd_data_ff[ENT_W-1:EXP_BITS];
   assign re  = rd_data_ff[EXP_BITS-1:0];
   assign ein = req_ff.exp_in[EXP_BITS-1:0];
   assign sum = rc + req_ff.coeff_in;

   // derivative terms with a zero product are dropped; a held word waits for
   // the next kept term so the final one can carry last
   assign skip     = (req_ff.operation == OP_DERIV) && (te_ff == '0 || prod_ff == '0);
   assign fin      = !(idx_ff + 1'b1 < count_ff);
   assign emit_out = !skip && any_ff;
   assign rsp_load = (state_ff == S_EMIT && emit_out) || state_ff == S_TAIL;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // memory port control
   always_comb begin
      rd_addr = idx_ff[IDX_BITS-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_BITS-1:0];
      wr_data = {req_ff.coeff_in, ein};
      if (state_ff == S_SHRD)
         rd_addr = sh_up_ff ? IDX_BITS'(sh_ff - 1'b1) : sh_ff[IDX_BITS-1:0];
      if (state_ff == S_SCAN && idx_ff < count_ff && re == ein) begin
         wr_en   = sum != '0;
         wr_data = {sum, ein};
      end
      if (state_ff == S_SHWR) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff;
         wr_addr = sh_up_ff ? sh_ff[IDX_BITS-1:0] : IDX_BITS'(sh_ff - 1'b1);
      end
      if (state_ff == S_SHRD && sh_up_ff && sh_ff == idx_ff) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[IDX_BITS-1:0];
         wr_data = {req_ff.coeff_in, ein};
      end
   end

   function automatic rsp_type mk(input logic [TCNT_W-1:0] n, input logic st);
      rsp_type r;
      r = '0;
      r.term_count = n;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type value_word(input logic [TCNT_W-1:0] n,
                                          input logic [COEFF_BITS-1:0] v);
      rsp_type r;
      r = mk(n, 1'b0);
      r.value = v;
      return r;
   endfunction

   function automatic rsp_type term_word(input logic [TCNT_W-1:0] n,
                                         input logic [COEFF_BITS-1:0] c,
                                         input logic [EXP_BITS-1:0] e,
                                         input logic lst);
      rsp_type r;
      r = mk(n, 1'b0);
      r.out_coeff  = c;
      r.out_exp    = EXP_W'(e);
      r.term_valid = 1'b1;
      r.last       = lst;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && !rsp_load) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  req_ff <= req.data;
                  idx_ff <= '0;
                  acc_ff <= '0;
                  any_ff <= 1'b0;
                  case (req.data.operation)
                     OP_INSERT, OP_EVAL, OP_LIST, OP_DERIV: begin
                        if (count_ff == '0) begin
                           rsp_ff <= mk(TCNT_W'(count_ff), 1'b0);
                           if (req.data.operation == OP_INSERT &&
                               req.data.coeff_in != '0) begin
                              state_ff <= S_SCAN;
                           end else begin
                              rsp_valid_ff <= 1'b1;
                           end
                        end else begin
                           state_ff <= S_RD;
                        end
                     end
                     OP_CLEAR: begin
                        count_ff     <= '0;
                        rsp_ff       <= mk('0, 1'b0);
                        rsp_valid_ff <= 1'b1;
                     end
                     default: begin
                        rsp_ff       <= mk(TCNT_W'(count_ff), 1'b0);
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_RD: state_ff <= S_WAIT;
            S_WAIT: state_ff <= (req_ff.operation == OP_INSERT) ? S_SCAN : S_TERM;
            S_SCAN: begin
               // insert: idx_ff entry data valid when idx_ff < count_ff
               if (idx_ff < count_ff && re == ein) begin
                  if (sum == '0) begin
                     sh_up_ff <= 1'b0;
                     sh_ff    <= idx_ff + 1'b1;
                     if (idx_ff + 1'b1 < count_ff) state_ff <= S_SHRD;
                     else begin
                        count_ff     <= count_ff - 1'b1;
                        rsp_ff       <= mk(TCNT_W'(count_ff - 1'b1), 1'b0);
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  end else begin
                     rsp_ff       <= mk(TCNT_W'(count_ff), 1'b0);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else if (idx_ff < count_ff && re > ein) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= (idx_ff + 1'b1 < count_ff) ? S_RD : S_SCAN;
               end else begin
                  // new exponent, place at idx_ff (later entries must not match:
                  // table is sorted, so re < ein means no match further on)
                  if (req_ff.coeff_in == '0) begin
                     rsp_ff       <= mk(TCNT_W'(count_ff), 1'b0);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else if (count_ff >= CNT_BITS'(MAX_TERMS)) begin
                     rsp_ff       <= mk(TCNT_W'(count_ff), 1'b1);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     sh_up_ff <= 1'b1;
                     sh_ff    <= count_ff;
                     state_ff <= S_SHRD;
                  end
               end
            end
            S_SHRD: begin
               if (sh_up_ff && sh_ff == idx_ff) begin
                  count_ff     <= count_ff + 1'b1;
                  rsp_ff       <= mk(TCNT_W'(count_ff + 1'b1), 1'b0);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_SHWR;
               end
            end
            S_SHWR: begin
               if (sh_up_ff) begin
                  sh_ff    <= sh_ff - 1'b1;
                  state_ff <= S_SHRD;
               end else begin
                  if (sh_ff + 1'b1 < count_ff) begin
                     sh_ff    <= sh_ff + 1'b1;
                     state_ff <= S_SHRD;
                  end else begin
                     count_ff     <= count_ff - 1'b1;
                     rsp_ff       <= mk(TCNT_W'(count_ff - 1'b1), 1'b0);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end
            end
            S_TERM: begin
               tc_ff <= rc;
               te_ff <= re;
               case (req_ff.operation)
                  OP_EVAL: begin
                     pw_ff    <= 32'd1;
                     base_ff  <= req_ff.x_value;
                     e_ff     <= re;
                     state_ff <= S_POW;
                  end
                  OP_DERIV: begin
                     prod_ff  <= rc * COEFF_BITS'(re);
                     state_ff <= S_EMIT;
                  end
                  default: begin
                     prod_ff  <= rc;
                     state_ff <= S_EMIT;
                  end
               endcase
            end
            S_POW: begin
               if (e_ff == '0) begin
                  prod_ff  <= tc_ff * pw_ff;
                  state_ff <= S_ACC;
               end else begin
                  if (e_ff[0]) pw_ff <= pw_ff * base_ff;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               base_ff  <= base_ff * base_ff;
               e_ff     <= e_ff >> 1;
               state_ff <= S_POW;
            end
            S_ACC: begin
               if (idx_ff + 1'b1 < count_ff) begin
                  acc_ff   <= acc_ff + prod_ff;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end else begin
                  rsp_ff       <= value_word(TCNT_W'(count_ff), acc_ff + prod_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_EMIT: begin
               if (!emit_out || !rsp_valid_ff || rsp.ready) begin
                  if (emit_out) begin
                     rsp_ff       <= term_word(TCNT_W'(count_ff), hold_c_ff,
                                               hold_e_ff, 1'b0);
                     rsp_valid_ff <= 1'b1;
                  end
                  if (!skip) begin
                     hold_c_ff <= prod_ff;
                     hold_e_ff <= (req_ff.operation == OP_DERIV) ? te_ff - 1'b1 : te_ff;
                     any_ff    <= 1'b1;
                  end
                  if (fin) state_ff <= S_TAIL;
                  else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end
            end
            S_TAIL: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff       <= any_ff ? term_word(TCNT_W'(count_ff), hold_c_ff,
                                                     hold_e_ff, 1'b1)
                                         : mk(TCNT_W'(count_ff), 1'b0);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
